### hdl/ebml_element_header_encoder_assert.svh
// ----------------------------------------------------------------------------
// EBML element header encoder assertion macros
// Shared assertion forms for the header encoder checker.
// ----------------------------------------------------------------------------
`ifndef EBML_ELEMENT_HEADER_ENCODER_ASSERT_SVH
`define EBML_ELEMENT_HEADER_ENCODER_ASSERT_SVH

// A condition seen at one edge implies the expression at the next.
`define EBMLH_HOLD(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("header encoder hold check failed");

// A condition seen at one edge implies the expression at the same edge.
`define EBMLH_CHECK(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("header encoder check failed");

`endif

### hdl/ebmlh_pkg.sv
// ----------------------------------------------------------------------------
// EBML header encoder package
// Types and fixed constants shared by the header encoder modules.
// ----------------------------------------------------------------------------
package ebmlh_pkg;

	// Field widths of one input word.
	localparam int ID_W    = 32;
	localparam int SIZE_W  = 56;
	localparam int LEN_W   = 4;
	localparam int IDCNT_W = 3;

	// Largest header in bytes: four ID bytes and eight size bytes.
	localparam int MAX_HDR_BYTES = 12;

	// Length marker of a one-byte size code.
	localparam logic [7:0] SIZE_MARKER = 8'h80;

	// Depth of the queue between the front and back parts.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// One classified header, ready for serialisation.
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SIZE_W-1:0]  val;
		logic [IDCNT_W-1:0] id_cnt;
		logic [LEN_W-1:0]   sz_cnt;
	} job_t;

endpackage

### hdl/ebml_element_header_encoder.sv
// ----------------------------------------------------------------------------
// EBML element header encoder
// Turns an element ID and size into the ID bytes and a size code.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Word
//  --------+---------------------+----------------------------------------
//  input   | in_valid / in_stall | element_id, size_value, forced_length
//  output  | out_valid/out_stall | out_byte, last_byte
//
// One output byte leaves per cycle while the output is not stalled, and a header
// has 1 to 12 bytes: its ID byte count plus its size length, with one output register.
// A taken word is written into the queue, then its first byte loads the output register.
// Reset clears the queue and the output valid; no clearing pass follows.
// The input stalls only while the two-entry queue is full, so output stalls
// reach the input after the queue has filled.
//
module ebml_element_header_encoder #(
	parameter int MAX_ID_BYTES   = 4,
	parameter int MAX_SIZE_BYTES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ebmlh_pkg::ID_W-1:0]   element_id,
	input  logic [ebmlh_pkg::SIZE_W-1:0] size_value,
	input  logic [ebmlh_pkg::LEN_W-1:0]  forced_length,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   out_byte,
	output logic                         last_byte
);
	import ebmlh_pkg::*;

	job_t fr_job;
	job_t q_head;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_head_valid;

	// Classification of incoming words.
	ebmlh_front #(
		.MAX_ID_BYTES   (MAX_ID_BYTES),
		.MAX_SIZE_BYTES (MAX_SIZE_BYTES)
	) u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_id    (element_id),
		.size_value    (size_value),
		.forced_length (forced_length),
		.q_full        (q_full),
		.push          (q_push),
		.job           (fr_job)
	);

	// Decoupling queue.
	ebmlh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_job     (fr_job),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid),
		.full       (q_full)
	);

	// Byte serialiser.
	ebmlh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_head_valid),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

endmodule

### hdl/ebmlh_front.sv
// ----------------------------------------------------------------------------
// EBML header encoder front part
// Accepts input words and works out the ID byte count and size length.
// ----------------------------------------------------------------------------
module ebmlh_front #(
	parameter int MAX_ID_BYTES   = 4,
	parameter int MAX_SIZE_BYTES = 8
) (
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ebmlh_pkg::ID_W-1:0]   element_id,
	input  logic [ebmlh_pkg::SIZE_W-1:0] size_value,
	input  logic [ebmlh_pkg::LEN_W-1:0]  forced_length,
	input  logic                         q_full,
	output logic                         push,
	output ebmlh_pkg::job_t              job
);
	import ebmlh_pkg::*;

	logic [ID_W-1:0]    id_kept;
	logic [IDCNT_W-1:0] id_cnt;
	logic [LEN_W-1:0]   min_len;
	logic [LEN_W-1:0]   sz_cnt;
	logic [SIZE_W-1:0]  low_mask;

	// The word is taken whenever the queue has room.
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Keep the low ID bytes and find the highest non-zero one.
	always_comb begin
		id_kept = '0;
		id_cnt  = '0;
		for (int b = 0; b < ID_W / 8; b++) begin
			if (b < MAX_ID_BYTES) begin
				id_kept[b*8 +: 8] = element_id[b*8 +: 8];
				if (element_id[b*8 +: 8] != 8'h00) begin
					id_cnt = IDCNT_W'(b + 1);
				end
			end
		end
	end

	// Minimal length: one more byte for each k where size+1 reaches 2^(7k).
	always_comb begin
		min_len  = LEN_W'(1);
		low_mask = '0;
		for (int k = 1; k < 8; k++) begin
			low_mask = {low_mask[SIZE_W-8:0], 7'h7f};
			if (k < MAX_SIZE_BYTES) begin
				if (((size_value & ~low_mask) != '0) ||
				    ((size_value | ~low_mask) == {SIZE_W{1'b1}})) begin
					min_len = LEN_W'(k + 1);
				end
			end
		end
	end

	// Forced lengths saturate at the largest size code.
	always_comb begin
		if (forced_length == '0) begin
			sz_cnt = min_len;
		end else if (forced_length > LEN_W'(MAX_SIZE_BYTES)) begin
			sz_cnt = LEN_W'(MAX_SIZE_BYTES);
		end else begin
			sz_cnt = forced_length;
		end
	end

	assign job.id     = id_kept;
	assign job.val    = size_value;
	assign job.id_cnt = id_cnt;
	assign job.sz_cnt = sz_cnt;

endmodule

### hdl/ebmlh_queue.sv
// ----------------------------------------------------------------------------
// EBML header encoder job queue
// A short first-in first-out store between the front and back parts.
// ----------------------------------------------------------------------------
module ebmlh_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ebmlh_pkg::job_t wr_job,
	input  logic            pop,
	output ebmlh_pkg::job_t head,
	output logic            head_valid,
	output logic            full
);
	import ebmlh_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### hdl/ebmlh_back.sv
// ----------------------------------------------------------------------------
// EBML header encoder back part
// Serialises one queued header into ID bytes and size code bytes.
// ----------------------------------------------------------------------------
module ebmlh_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ebmlh_pkg::job_t head,
	input  logic            head_valid,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            last_byte
);
	import ebmlh_pkg::*;

	logic               active_q;
	job_t               job_q;
	logic [IDCNT_W-1:0] id_left_q;
	logic [LEN_W-1:0]   sz_left_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               last_q;

	job_t               src;
	logic [IDCNT_W-1:0] cur_id_left;
	logic [LEN_W-1:0]   cur_sz_left;
	logic [IDCNT_W-1:0] id_idx;
	logic [LEN_W-1:0]   sz_idx;
	logic [LEN_W-1:0]   top_idx;
	logic [63:0]        val_ext;
	logic [7:0]         id_sel;
	logic [7:0]         val_sel;
	logic [7:0]         marker;
	logic               is_id;
	logic               adv;
	logic               emit;
	logic [7:0]         byte_d;
	logic               last_d;
	logic [IDCNT_W-1:0] id_left_d;
	logic [LEN_W-1:0]   sz_left_d;

	// Work from the held header, or straight from the queue head when idle.
	always_comb begin
		src         = active_q ? job_q : head;
		cur_id_left = active_q ? id_left_q : head.id_cnt;
		cur_sz_left = active_q ? sz_left_q : head.sz_cnt;
	end

	// The output register moves when empty or when its word is taken.
	assign adv  = !out_valid_q || !out_stall;
	assign emit = adv && (active_q || head_valid);
	assign pop  = emit && !active_q;

	// Byte selection: ID bytes high first, then the size code.
	always_comb begin
		id_idx  = cur_id_left - IDCNT_W'(1);
		sz_idx  = cur_sz_left - LEN_W'(1);
		top_idx = src.sz_cnt - LEN_W'(1);
		val_ext = {{(64 - SIZE_W){1'b0}}, src.val};
		id_sel  = src.id[{id_idx[1:0], 3'b000} +: 8];
		val_sel = val_ext[{sz_idx[2:0], 3'b000} +: 8];
		marker  = SIZE_MARKER >> top_idx[2:0];
		is_id   = (cur_id_left != '0);
		if (is_id) begin
			byte_d    = id_sel;
			last_d    = 1'b0;
			id_left_d = id_idx;
			sz_left_d = cur_sz_left;
		end else begin
			byte_d    = val_sel | ((cur_sz_left == src.sz_cnt) ? marker : 8'h00);
			last_d    = (cur_sz_left == LEN_W'(1));
			id_left_d = cur_id_left;
			sz_left_d = sz_idx;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				active_q    <= !last_d;
			end else if (adv) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Header and output word registers.
	always_ff @(posedge clk) begin
		if (emit) begin
			job_q      <= src;
			id_left_q  <= id_left_d;
			sz_left_q  <= sz_left_d;
			out_byte_q <= byte_d;
			last_q     <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

endmodule

### hdl/ebmlh_checker.sv
// ----------------------------------------------------------------------------
// EBML header encoder port checker
// Watches the top-level ports for output holding and header framing.
// ----------------------------------------------------------------------------
`include "ebml_element_header_encoder_assert.svh"

module ebmlh_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [ebmlh_pkg::ID_W-1:0]   element_id,
	input logic [ebmlh_pkg::SIZE_W-1:0] size_value,
	input logic [ebmlh_pkg::LEN_W-1:0]  forced_length,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [7:0]                   out_byte,
	input logic                         last_byte
);
	import ebmlh_pkg::*;

	logic       in_acc;
	logic       out_acc;
	logic       id_seen;
	logic [3:0] pend_q;
	logic [3:0] run_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign id_seen = (element_id != '0) || (size_value != '0) || (forced_length != '0);

	// Headers taken in but not yet closed, and bytes since the last close.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			run_q  <= '0;
		end else begin
			if (in_acc && !(out_acc && last_byte)) begin
				pend_q <= pend_q + 4'd1;
			end else if (!in_acc && out_acc && last_byte) begin
				pend_q <= pend_q - 4'd1;
			end
			if (out_acc) begin
				run_q <= last_byte ? 4'd0 : run_q + 4'd1;
			end
		end
	end

	`EBMLH_HOLD(a_out_valid_holds, out_valid && out_stall, out_valid)
	`EBMLH_HOLD(a_out_word_holds, out_valid && out_stall, $stable(out_byte) && $stable(last_byte))
	`EBMLH_CHECK(a_out_has_header, out_valid, pend_q != 4'd0 || (in_acc && !id_seen && 1'b0))
	`EBMLH_CHECK(a_header_bounded, out_acc && !last_byte, run_q < 4'(MAX_HDR_BYTES - 1))

endmodule

bind ebml_element_header_encoder ebmlh_checker u_ebmlh_checker (.*);

### test/tb_ebml_element_header_encoder.sv
// ----------------------------------------------------------------------------
// EBML element header encoder testbench
// Sends element headers (ID, size and forced length) into the encoder and
// checks every emitted byte and its end-of-header flag against a predicted
// byte stream. Both channels idle at random, and the receiver holds off once
// for long enough that the encoder fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_ebml_element_header_encoder;
	import ebmlh_pkg::*;

	localparam int ID_BYTES   = 4;
	localparam int SIZE_BYTES = 8;
	localparam int HALF_CLK   = 6;
	localparam int RUN_LIMIT  = 12 * 60000;
	localparam int RANDOM_HEADERS = 128;
	localparam int HOLD_OFF_CYCLES = 100;

	// One predicted output word.
	typedef struct {
		logic [7:0] value;
		logic       is_last;
	} hdr_byte_t;

	// Predicts the byte stream of each accepted header and checks the output.
	class header_byte_scoreboard;
		hdr_byte_t expected_bytes[$];
		int        mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void note_header(logic [ID_W-1:0] id, logic [SIZE_W-1:0] sz,
			logic [LEN_W-1:0] fl);
			logic [63:0] kept_id;
			logic [63:0] wide_sz;
			logic [7:0]  lead;
			int          id_len;
			int          code_len;
			kept_id = {32'd0, id};
			if (ID_BYTES < 4)
				kept_id = kept_id & ((64'd1 << (8 * ID_BYTES)) - 64'd1);
			wide_sz = {8'd0, sz};

			// Significant ID bytes, most significant first.
			id_len = 0;
			for (int k = 0; k < ID_BYTES; k++) begin
				if (kept_id[8*k +: 8] != 8'd0)
					id_len = k + 1;
			end
			for (int k = id_len - 1; k >= 0; k--)
				expected_bytes.push_back(hdr_byte_t'{kept_id[8*k +: 8], 1'b0});

			// Code length: minimal, forced, or saturated at the largest size.
			if (fl == '0) begin
				code_len = 1;
				while (code_len < SIZE_BYTES && (wide_sz + 64'd1) >= (64'd1 << (7 * code_len)))
					code_len++;
			end else if (fl > SIZE_BYTES) begin
				code_len = SIZE_BYTES;
			end else begin
				code_len = fl;
			end

			// Leading byte carries the length marker over the top value bits.
			lead = (SIZE_MARKER >> (code_len - 1)) | wide_sz[8*(code_len-1) +: 8];
			expected_bytes.push_back(hdr_byte_t'{lead, code_len == 1});
			for (int k = code_len - 2; k >= 0; k--)
				expected_bytes.push_back(hdr_byte_t'{wide_sz[8*k +: 8], k == 0});
		endfunction

		function void check_byte(logic [7:0] value, logic is_last);
			hdr_byte_t want;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte, expected none, actual %h last %b",
					$time, value, is_last);
				mismatches++;
				return;
			end
			want = expected_bytes.pop_front();
			if (value !== want.value) begin
				$display("%0t: out_byte expected %h actual %h", $time, want.value, value);
				mismatches++;
			end
			if (is_last !== want.is_last) begin
				$display("%0t: last_byte expected %b actual %b", $time, want.is_last, is_last);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [ID_W-1:0]     element_id;
	logic [SIZE_W-1:0]   size_value;
	logic [LEN_W-1:0]    forced_length;
	logic                out_valid;
	logic                out_stall;
	logic [7:0]          out_byte;
	logic                last_byte;

	header_byte_scoreboard sb = new();
	int                    headers_sent = 0;

	ebml_element_header_encoder #(
		.MAX_ID_BYTES  (ID_BYTES),
		.MAX_SIZE_BYTES(SIZE_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.element_id   (element_id),
		.size_value   (size_value),
		.forced_length(forced_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_byte    (last_byte)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #HALF_CLK clk = ~clk;
	end

	// The run ends here if the encoder hangs.
	initial begin
		#RUN_LIMIT;
		$display("Mismatches found");
		$finish;
	end

	// Offers one header and waits for it to be taken; may then drop its valid.
	task automatic send_header(logic [ID_W-1:0] id, logic [SIZE_W-1:0] sz,
		logic [LEN_W-1:0] fl);
		element_id    <= id;
		size_value    <= sz;
		forced_length <= fl;
		in_valid      <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.note_header(id, sz, fl);
		headers_sent++;
		@(negedge clk);
		// No idle gap follows headers 60 to 109.
		if (!(headers_sent >= 60 && headers_sent < 110) && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	function automatic logic [ID_W-1:0] random_id();
		int          nbytes;
		logic [63:0] r;
		nbytes = $urandom_range(0, 4);
		r = {32'd0, $urandom};
		r = r & ((64'd1 << (8 * nbytes)) - 64'd1);
		return r[ID_W-1:0];
	endfunction

	// Sizes of random width, with length boundaries hit often.
	function automatic logic [SIZE_W-1:0] random_size();
		int          width;
		logic [63:0] r;
		if ($urandom_range(0, 4) == 0) begin
			width = 7 * $urandom_range(1, 8);
			r = (64'd1 << width) - 64'd1 - 64'($urandom_range(0, 1));
		end else begin
			width = $urandom_range(0, 56);
			r = {$urandom, $urandom};
			r = r & ((64'd1 << width) - 64'd1);
		end
		if (r[SIZE_W-1:0] == '1)
			r = r - 64'd1;
		return r[SIZE_W-1:0];
	endfunction

	// Edge values, every length, forced and saturated codes.
	task automatic run_directed();
		send_header(32'h0, 56'd0, 4'd0);
		send_header(32'hFFFF_FFFF, 56'hFF_FFFF_FFFF_FFFE, 4'd0);
		send_header(32'h1A45_DFA3, 56'd126, 4'd0);
		send_header(32'h42, 56'd127, 4'd0);
		send_header(32'h4286, 56'd16382, 4'd0);
		send_header(32'h2A_D7B1, 56'd16383, 4'd0);
		send_header(32'h0100_0000, 56'h1_FFFF_FFFF_FFFE, 4'd0);
		send_header(32'h0001_0000, 56'h1_FFFF_FFFF_FFFF, 4'd0);
		send_header(32'h0, 56'hFF_FFFF_FFFF_FFFE, 4'd8);
		for (int k = 1; k <= 8; k++)
			send_header(32'h1853_8067, 56'h12_3456_789A_BCDE, 4'(k));
		send_header(32'hA3, 56'd5, 4'd9);
		send_header(32'hA3, 56'hAA_5555_AAAA_5555, 4'd15);
		send_header(32'h80, 56'h00_0000_0000_FFFF, 4'd1);
		send_header(32'h0, 56'd0, 4'd1);
		send_header(32'hFF00_00FF, 56'h7F, 4'd2);
	endtask

	// Stimulus and end of run.
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		element_id    = '0;
		size_value    = '0;
		forced_length = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		for (int k = 0; k < RANDOM_HEADERS; k++)
			send_header(random_id(), random_size(),
				($urandom_range(0, 99) < 50) ? 4'd0 : 4'($urandom_range(1, 15)));
		in_valid <= 1'b0;
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver back-pressure: random stalls, one long hold-off, one clean stretch.
	initial begin
		bit held_off;
		held_off  = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && headers_sent >= 40) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (headers_sent >= 110 && headers_sent < 150) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 9);
			end
		end
	end

	// Every byte taken by the receiver is checked.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_byte(out_byte, last_byte);
	end

endmodule
